// ===== hw/rtl/rbl_pkg.sv =====
// Shared types and codes for the random-bit leader election node.
// No dependencies; used by every module under hw/rtl.
package rbl_pkg;

  typedef enum logic [1:0] {
    MODE_TICK     = 2'd0,
    MODE_BIT      = 2'd1,
    MODE_ANNOUNCE = 2'd2,
    MODE_NONE     = 2'd3
  } rbl_mode_e;

  typedef enum logic [1:0] {
    ROLE_ACTIVE  = 2'd0,
    ROLE_PASSIVE = 2'd1,
    ROLE_LEADER  = 2'd2
  } rbl_role_e;

  typedef enum logic [2:0] {
    ACT_BCAST    = 3'd0,
    ACT_FWD_BIT  = 3'd1,
    ACT_FWD_ANN  = 3'd2,
    ACT_ANNOUNCE = 3'd3,
    ACT_REARM    = 3'd4
  } rbl_action_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CB,
    S_EVAL,
    S_RREQ,
    S_RDAT,
    S_FIN
  } rbl_state_e;

  localparam logic [1:0] CFG_OWN_ID    = 2'd0;
  localparam logic [1:0] CFG_NODE_CNT  = 2'd1;
  localparam logic [1:0] CFG_NEIGH_CNT = 2'd2;

  // buffered bit message
  typedef struct packed {
    logic [3:0]  port;
    logic        act;
    logic [15:0] rnd;
    logic        bit_v;
    logic [3:0]  snd;
  } rbl_entry_t;

  typedef struct packed {
    rbl_action_e action;
    logic [1:0]  role;
    logic [3:0]  snd;
    logic        bit_v;
    logic [15:0] rnd;
    logic        act;
    logic [3:0]  skip_port;
    logic        skip_valid;
    logic [3:0]  leader;
    logic        ovf;
  } rbl_res_t;

endpackage

// ===== hw/rtl/random_bit_leader_election_node_unit.sv =====
// One node of a round-based random-bit leader election.
// Input channel: in_valid_i / in_stall_o carry one request (tick, bit
//   message or leader announcement). Output channel: out_valid_o /
//   out_stall_i carry the resulting actions, one per transfer, the final
//   one of a request flagged by last_o. A request may give no action.
// Config port: cfg_we_i writes own id, node count or neighbour count;
//   the user must write only while the node is idle; the block itself does
//   not enforce this. Writing the node count reloads the active bitmap.
// Tick: after the broadcast the sequencer reads each buffered message in
//   turn, replays those of the new round, compacts the rest and runs at
//   most two round evaluations. The replay is bound by the single read
//   port of the future buffer. One request is worked on at a time;
//   in_stall_o is low only when the sequencer is idle and the output
//   register can take a result.
// Stall: while the receiver stalls a valid result, the sequencer halts;
//   nothing is lost or repeated.
// Reset: role active, round 0, heard set empty, all nodes active, future
//   buffer empty (contents undefined, only valid entries are read).
module random_bit_leader_election_node_unit #(
  parameter int MAX_NODES    = 16,
  parameter int FUTURE_DEPTH = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [4:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  mode_i,
  input  logic [3:0]  sender_id_i,
  input  logic        bit_value_i,
  input  logic [15:0] round_number_i,
  input  logic        sender_active_i,
  input  logic [3:0]  arrival_port_i,
  input  logic [3:0]  announced_leader_i,
  input  logic        random_bit_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  action_o,
  output logic [1:0]  node_role_o,
  output logic [3:0]  out_sender_o,
  output logic        out_bit_o,
  output logic [15:0] out_round_o,
  output logic        out_active_o,
  output logic [3:0]  skip_port_o,
  output logic        skip_valid_o,
  output logic [3:0]  out_leader_o,
  output logic        buffer_overflow_o,
  output logic        last_o
);

  localparam int IW = $clog2(MAX_NODES);
  localparam int HW = $clog2(MAX_NODES + 1);
  localparam int CW = $clog2(FUTURE_DEPTH + 1);
  localparam int FW = (FUTURE_DEPTH > 1) ? $clog2(FUTURE_DEPTH) : 1;

  rbl_pkg::rbl_state_e state_q, state_d;
  rbl_pkg::rbl_role_e  role_q, role_d;
  logic [15:0]          round_q, round_d;
  logic                 my_bit_q, my_bit_d;
  logic [MAX_NODES-1:0] heard_mask_q, heard_mask_d;
  logic [MAX_NODES-1:0] heard_bits_q, heard_bits_d;
  logic [MAX_NODES-1:0] active_mask_q, active_mask_d;
  logic [HW-1:0]        heard_cnt_q, heard_cnt_d;
  logic                 ovf_q, ovf_d;
  logic [CW-1:0]        cnt_q, cnt_d, rd_q, rd_d, wr_q, wr_d;
  logic                 replay_q, replay_d;
  rbl_pkg::rbl_entry_t  cb_q, cb_d;
  logic [3:0]           own_q, own_d;
  logic [4:0]           nc_q, nc_d;
  logic [3:0]           nb_q, nb_d;

  logic                mem_we, mem_re;
  logic [FW-1:0]       mem_waddr, mem_raddr;
  rbl_pkg::rbl_entry_t mem_wdata, mem_rdata;

  logic              push, fin, go, accept;
  rbl_pkg::rbl_res_t res, out_res;

  // shared decisions
  logic               cb_take, cb_eval, rd_more, tick_eval, rd_match, own_ok;
  logic [IW-1:0]      sidx, own_idx;
  logic [HW:0]        ones, actives;
  rbl_pkg::rbl_role_e role_eval;

  assign accept = in_valid_i && !in_stall_o;
  assign in_stall_o = !(state_q == rbl_pkg::S_IDLE && go);

  assign sidx    = IW'(cb_q.snd);
  assign own_idx = IW'(own_q);
  assign own_ok  = 32'(own_q) < MAX_NODES;
  assign cb_take = (32'(cb_q.snd) < MAX_NODES) && (cb_q.snd != own_q) && !heard_mask_q[sidx];
  assign cb_eval = (nc_q != 5'd0) &&
                   ((8'(heard_cnt_q) + 8'd1) == (8'(nc_q) - 8'd1));
  assign rd_more   = rd_q < cnt_q;
  assign tick_eval = (nc_q == 5'd1) || (nb_q == 4'd0);
  assign rd_match  = mem_rdata.rnd == round_q;
  assign ones      = (HW+1)'(my_bit_q) + (HW+1)'($countones(heard_bits_q));
  assign actives   = (HW+1)'($countones(active_mask_q));

  always_comb begin
    role_eval = role_q;
    if (role_q == rbl_pkg::ROLE_ACTIVE) begin
      if (ones == (HW+1)'(1) && my_bit_q) begin
        role_eval = rbl_pkg::ROLE_LEADER;
      end else if (ones == (HW+1)'(1)) begin
        role_eval = rbl_pkg::ROLE_PASSIVE;
      end else if (ones > (HW+1)'(1) && ones < actives && !my_bit_q) begin
        role_eval = rbl_pkg::ROLE_PASSIVE;
      end
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    if (go) begin
      case (state_q)
        rbl_pkg::S_IDLE: begin
          if (accept) begin
            if (mode_i == rbl_pkg::MODE_TICK) begin
              state_d = rbl_pkg::S_RREQ;
            end else if (mode_i == rbl_pkg::MODE_BIT && round_number_i == round_q) begin
              state_d = rbl_pkg::S_CB;
            end else begin
              state_d = rbl_pkg::S_FIN;
            end
          end
        end
        rbl_pkg::S_CB: begin
          if (cb_take && cb_eval) begin
            state_d = rbl_pkg::S_EVAL;
          end else begin
            state_d = replay_q ? rbl_pkg::S_RREQ : rbl_pkg::S_FIN;
          end
        end
        rbl_pkg::S_EVAL: state_d = replay_q ? rbl_pkg::S_RREQ : rbl_pkg::S_FIN;
        rbl_pkg::S_RREQ: begin
          if (rd_more) begin
            state_d = rbl_pkg::S_RDAT;
          end else begin
            state_d = tick_eval ? rbl_pkg::S_EVAL : rbl_pkg::S_FIN;
          end
        end
        rbl_pkg::S_RDAT: state_d = rd_match ? rbl_pkg::S_CB : rbl_pkg::S_RREQ;
        rbl_pkg::S_FIN:  state_d = rbl_pkg::S_IDLE;
        default:         state_d = rbl_pkg::S_IDLE;
      endcase
    end
  end

  // datapath and results
  always_comb begin
    role_d        = role_q;
    round_d       = round_q;
    my_bit_d      = my_bit_q;
    heard_mask_d  = heard_mask_q;
    heard_bits_d  = heard_bits_q;
    active_mask_d = active_mask_q;
    heard_cnt_d   = heard_cnt_q;
    ovf_d         = ovf_q;
    cnt_d         = cnt_q;
    rd_d          = rd_q;
    wr_d          = wr_q;
    replay_d      = replay_q;
    cb_d          = cb_q;
    own_d         = own_q;
    nc_d          = nc_q;
    nb_d          = nb_q;
    mem_we        = 1'b0;
    mem_waddr     = wr_q[FW-1:0];
    mem_wdata     = mem_rdata;
    mem_re        = 1'b0;
    mem_raddr     = rd_q[FW-1:0];
    push          = 1'b0;
    fin           = 1'b0;
    res           = '0;
    res.role      = role_q;
    res.ovf       = ovf_q;

    if (go) begin
      case (state_q)
        rbl_pkg::S_IDLE: begin
          if (accept) begin
            case (mode_i)
              rbl_pkg::MODE_TICK: begin
                round_d      = (round_q == 16'hFFFF) ? round_q : round_q + 16'd1;
                heard_mask_d = '0;
                heard_bits_d = '0;
                heard_cnt_d  = '0;
                my_bit_d     = (role_q == rbl_pkg::ROLE_ACTIVE) ? random_bit_i : 1'b0;
                rd_d         = '0;
                wr_d         = '0;
                replay_d     = 1'b1;
                push         = 1'b1;
                res.action   = rbl_pkg::ACT_BCAST;
                res.snd      = own_q;
                res.bit_v    = my_bit_d;
                res.rnd      = round_d;
                res.act      = role_q == rbl_pkg::ROLE_ACTIVE;
              end
              rbl_pkg::MODE_BIT: begin
                cb_d.snd   = sender_id_i;
                cb_d.bit_v = bit_value_i;
                cb_d.rnd   = round_number_i;
                cb_d.act   = sender_active_i;
                cb_d.port  = arrival_port_i;
                replay_d   = 1'b0;
                if (round_number_i > round_q) begin
                  if (cnt_q < CW'(FUTURE_DEPTH)) begin
                    mem_we    = 1'b1;
                    mem_waddr = cnt_q[FW-1:0];
                    mem_wdata = cb_d;
                    cnt_d     = cnt_q + CW'(1);
                  end else begin
                    ovf_d = 1'b1;
                  end
                end
              end
              rbl_pkg::MODE_ANNOUNCE: begin
                if (role_q == rbl_pkg::ROLE_ACTIVE) begin
                  role_d = rbl_pkg::ROLE_PASSIVE;
                  if (own_ok) begin
                    active_mask_d[own_idx] = 1'b0;
                  end
                  push           = 1'b1;
                  res.action     = rbl_pkg::ACT_FWD_ANN;
                  res.role       = rbl_pkg::ROLE_PASSIVE;
                  res.skip_port  = arrival_port_i;
                  res.skip_valid = 1'b1;
                  res.leader     = announced_leader_i;
                end
              end
              default: ;
            endcase
          end
        end
        rbl_pkg::S_CB: begin
          if (cb_take) begin
            heard_mask_d[sidx]  = 1'b1;
            heard_bits_d[sidx]  = cb_q.bit_v;
            active_mask_d[sidx] = cb_q.act;
            heard_cnt_d         = heard_cnt_q + HW'(1);
            push                = 1'b1;
            res.action          = rbl_pkg::ACT_FWD_BIT;
            res.snd             = cb_q.snd;
            res.bit_v           = cb_q.bit_v;
            res.rnd             = round_q;
            res.act             = cb_q.act;
            res.skip_port       = cb_q.port;
            res.skip_valid      = 1'b1;
          end
        end
        rbl_pkg::S_EVAL: begin
          role_d = role_eval;
          if (role_q == rbl_pkg::ROLE_ACTIVE && role_eval == rbl_pkg::ROLE_PASSIVE
              && own_ok) begin
            active_mask_d[own_idx] = 1'b0;
          end
          if (role_q != rbl_pkg::ROLE_LEADER) begin
            push     = 1'b1;
            res.role = role_eval;
            if (role_eval == rbl_pkg::ROLE_LEADER) begin
              res.action = rbl_pkg::ACT_ANNOUNCE;
              res.leader = own_q;
            end else begin
              res.action = rbl_pkg::ACT_REARM;
            end
          end
        end
        rbl_pkg::S_RREQ: begin
          if (rd_more) begin
            mem_re = 1'b1;
          end else begin
            cnt_d    = wr_q;
            replay_d = 1'b0;
          end
        end
        rbl_pkg::S_RDAT: begin
          rd_d = rd_q + CW'(1);
          if (rd_match) begin
            cb_d = mem_rdata;
          end else begin
            // compact survivors towards the head, order kept
            mem_we = 1'b1;
            wr_d   = wr_q + CW'(1);
          end
        end
        rbl_pkg::S_FIN: fin = 1'b1;
        default: ;
      endcase
    end

    if (cfg_we_i) begin
      case (cfg_idx_i)
        rbl_pkg::CFG_OWN_ID:    own_d = cfg_data_i[3:0];
        rbl_pkg::CFG_NODE_CNT: begin
          nc_d = cfg_data_i;
          for (int j = 0; j < MAX_NODES; j++) begin
            active_mask_d[j] = 32'(j) < 32'(cfg_data_i);
          end
        end
        rbl_pkg::CFG_NEIGH_CNT: nb_d = cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= rbl_pkg::S_IDLE;
      role_q        <= rbl_pkg::ROLE_ACTIVE;
      round_q       <= '0;
      my_bit_q      <= 1'b0;
      heard_mask_q  <= '0;
      heard_bits_q  <= '0;
      active_mask_q <= '1;
      heard_cnt_q   <= '0;
      ovf_q         <= 1'b0;
      cnt_q         <= '0;
      rd_q          <= '0;
      wr_q          <= '0;
      replay_q      <= 1'b0;
      own_q         <= 4'd0;
      nc_q          <= 5'd16;
      nb_q          <= 4'd15;
    end else begin
      state_q       <= state_d;
      role_q        <= role_d;
      round_q       <= round_d;
      my_bit_q      <= my_bit_d;
      heard_mask_q  <= heard_mask_d;
      heard_bits_q  <= heard_bits_d;
      active_mask_q <= active_mask_d;
      heard_cnt_q   <= heard_cnt_d;
      ovf_q         <= ovf_d;
      cnt_q         <= cnt_d;
      rd_q          <= rd_d;
      wr_q          <= wr_d;
      replay_q      <= replay_d;
      own_q         <= own_d;
      nc_q          <= nc_d;
      nb_q          <= nb_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cb_q <= cb_d;
  end

  rbl_fmem #(
    .DEPTH (FUTURE_DEPTH),
    .AW    (FW)
  ) u_fmem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  rbl_outreg u_outreg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .fin_i       (fin),
    .res_i       (res),
    .ready_o     (go),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_res_o   (out_res),
    .out_last_o  (last_o)
  );

  assign action_o          = out_res.action;
  assign node_role_o       = out_res.role;
  assign out_sender_o      = out_res.snd;
  assign out_bit_o         = out_res.bit_v;
  assign out_round_o       = out_res.rnd;
  assign out_active_o      = out_res.act;
  assign skip_port_o       = out_res.skip_port;
  assign skip_valid_o      = out_res.skip_valid;
  assign out_leader_o      = out_res.leader;
  assign buffer_overflow_o = out_res.ovf;

  a_heard_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(heard_cnt_q) == $countones(heard_mask_q))
    else $error("heard count out of step with heard mask");

  a_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cnt_q) <= FUTURE_DEPTH)
    else $error("future buffer fill beyond depth");

  a_compact: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_q <= rd_q)
    else $error("compaction write passed read");

  a_leader_stays: assert property (@(posedge clk_i) disable iff (!rst_ni)
    role_q == rbl_pkg::ROLE_LEADER |=> role_q == rbl_pkg::ROLE_LEADER)
    else $error("leader role left");

endmodule

// ===== hw/rtl/rbl_fmem.sv =====
// Future-message buffer: single write port, single registered read port.
// Depends on rbl_pkg.
module rbl_fmem #(
  parameter int DEPTH = 8,
  parameter int AW    = 3
) (
  input  logic               clk_i,
  input  logic               we_i,
  input  logic [AW-1:0]      waddr_i,
  input  rbl_pkg::rbl_entry_t wdata_i,
  input  logic               re_i,
  input  logic [AW-1:0]      raddr_i,
  output rbl_pkg::rbl_entry_t rdata_o
);

  rbl_pkg::rbl_entry_t mem_q [DEPTH];
  rbl_pkg::rbl_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/rbl_outreg.sv =====
// Result staging: holds one pending result so the last flag can be set,
// then an output register towards the receiver. Depends on rbl_pkg.
module rbl_outreg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic              fin_i,
  input  rbl_pkg::rbl_res_t res_i,
  output logic              ready_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output rbl_pkg::rbl_res_t out_res_o,
  output logic              out_last_o
);

  logic              pend_v_q;
  rbl_pkg::rbl_res_t pend_q;
  logic              out_valid_q;
  rbl_pkg::rbl_res_t out_q;
  logic              last_q;
  logic              load;

  assign ready_o = !out_valid_q || !out_stall_i;
  assign load    = pend_v_q && (push_i || fin_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (push_i) begin
        pend_v_q <= 1'b1;
      end else if (fin_i) begin
        pend_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      pend_q <= res_i;
    end
    if (load) begin
      out_q  <= pend_q;
      last_q <= fin_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;
  assign out_last_o  = last_q;

endmodule

// ===== tb/random_bit_leader_election_node_unit_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for random_bit_leader_election_node_unit.
// Depends on rbl_pkg and the node RTL only; built-in predictor, no files.
module random_bit_leader_election_node_unit_test;

  localparam int FUT_DEPTH = 8;
  localparam int MAX_ACTIONS = 26;
  localparam int WATCHDOG = 4000;   // cycles with no transfer on either side
  localparam int SETTLE = 60;       // covers a full replay after the last action
  localparam int PHASES = 8;
  localparam int PHASE_REQS = 55;

  // one request as driven on the input channel
  typedef struct {
    logic [1:0]  mode;
    logic [3:0]  snd;
    logic        bitv;
    logic [15:0] rnd;
    logic        sact;
    logic [3:0]  port;
    logic [3:0]  ldr;
    logic        rbit;
  } request_t;

  // one action as seen on the output channel
  typedef struct {
    rbl_pkg::rbl_action_e action;
    logic [1:0]  role;
    logic [3:0]  snd;
    logic        bitv;
    logic [15:0] rnd;
    logic        act;
    logic [3:0]  skip_port;
    logic        skip_valid;
    logic [3:0]  leader;
    logic        ovf;
    logic        last;
  } action_t;

  // directed row: typed rows carry their answer (or none) instead of the predictor's
  typedef struct {
    request_t req;
    bit       typed;
    bit       silent;
    action_t  want;
  } row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [4:0]  cfg_data_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [1:0]  mode_i;
  logic [3:0]  sender_id_i;
  logic        bit_value_i;
  logic [15:0] round_number_i;
  logic        sender_active_i;
  logic [3:0]  arrival_port_i;
  logic [3:0]  announced_leader_i;
  logic        random_bit_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [2:0]  action_o;
  logic [1:0]  node_role_o;
  logic [3:0]  out_sender_o;
  logic        out_bit_o;
  logic [15:0] out_round_o;
  logic        out_active_o;
  logic [3:0]  skip_port_o;
  logic        skip_valid_o;
  logic [3:0]  out_leader_o;
  logic        buffer_overflow_o;
  logic        last_o;

  random_bit_leader_election_node_unit dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .mode_i             (mode_i),
    .sender_id_i        (sender_id_i),
    .bit_value_i        (bit_value_i),
    .round_number_i     (round_number_i),
    .sender_active_i    (sender_active_i),
    .arrival_port_i     (arrival_port_i),
    .announced_leader_i (announced_leader_i),
    .random_bit_i       (random_bit_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .action_o           (action_o),
    .node_role_o        (node_role_o),
    .out_sender_o       (out_sender_o),
    .out_bit_o          (out_bit_o),
    .out_round_o        (out_round_o),
    .out_active_o       (out_active_o),
    .skip_port_o        (skip_port_o),
    .skip_valid_o       (skip_valid_o),
    .out_leader_o       (out_leader_o),
    .buffer_overflow_o  (buffer_overflow_o),
    .last_o             (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------
  // Node predictor: own copy of registers and election state
  // ---------------------------------------------------------------------
  logic [3:0]  nd_own;
  logic [4:0]  nd_nodes;
  logic [3:0]  nd_neigh;
  rbl_pkg::rbl_role_e  nd_role;
  logic [15:0] nd_round;
  logic        nd_mybit;
  logic [15:0] nd_heard;     // senders heard this round
  logic [15:0] nd_ones;      // their bits
  logic [15:0] nd_active;    // active bitmap
  logic        nd_ovf;
  rbl_pkg::rbl_entry_t nd_future[$]; // early messages, arrival order

  action_t     step_actions[$];    // actions of the request being predicted
  action_t     pending_actions[$]; // expected, oldest first
  int          fails = 0;
  int          idle_pct = 0;
  int          stall_pct = 0;
  bit          allow_announce = 1'b0;

  function automatic void note_action(rbl_pkg::rbl_action_e a, logic [3:0] s, logic b,
                                      logic [15:0] r, logic f, logic [3:0] p,
                                      logic pv, logic [3:0] l);
    action_t x;
    if (step_actions.size() >= MAX_ACTIONS) return;
    x.action = a; x.role = nd_role; x.snd = s; x.bitv = b; x.rnd = r; x.act = f;
    x.skip_port = p; x.skip_valid = pv; x.leader = l; x.ovf = nd_ovf; x.last = 1'b0;
    step_actions = {step_actions, x};
  endfunction

  function automatic void drop_out();
    nd_role = rbl_pkg::ROLE_PASSIVE;
    nd_active[nd_own] = 1'b0;
  endfunction

  // round evaluation once every other node has spoken, or at a tick with one node or no neighbours
  function automatic void judge_round();
    int ones;
    int actives;
    ones = nd_mybit + $countones(nd_ones & nd_heard);
    actives = $countones(nd_active);
    if (nd_role == rbl_pkg::ROLE_ACTIVE) begin
      if (ones == 1 && nd_mybit) begin
        nd_role = rbl_pkg::ROLE_LEADER;
        note_action(rbl_pkg::ACT_ANNOUNCE, 4'd0, 1'b0, 16'd0, 1'b0, 4'd0, 1'b0, nd_own);
      end else if (ones == 1) begin
        drop_out();
      end else if (ones > 1 && ones < actives && !nd_mybit) begin
        drop_out();
      end
    end
    if (nd_role != rbl_pkg::ROLE_LEADER)
      note_action(rbl_pkg::ACT_REARM, 4'd0, 1'b0, 16'd0, 1'b0, 4'd0, 1'b0, 4'd0);
  endfunction

  function automatic void hear_bit(logic [3:0] s, logic b, logic f, logic [3:0] p);
    if (s == nd_own || nd_heard[s]) return;
    nd_heard[s] = 1'b1;
    nd_ones[s] = b;
    nd_active[s] = f;
    note_action(rbl_pkg::ACT_FWD_BIT, s, b, nd_round, f, p, 1'b1, 4'd0);
    if (nd_nodes != 0 && $countones(nd_heard) == int'(nd_nodes) - 1) judge_round();
  endfunction

  function automatic void predict_request(request_t r);
    int i;
    rbl_pkg::rbl_entry_t e;
    step_actions.delete();
    case (r.mode)
      rbl_pkg::MODE_TICK: begin
        if (nd_round != 16'hFFFF) nd_round++;
        nd_heard = '0;
        nd_ones = '0;
        nd_mybit = (nd_role == rbl_pkg::ROLE_ACTIVE) ? r.rbit : 1'b0;
        note_action(rbl_pkg::ACT_BCAST, nd_own, nd_mybit, nd_round,
                    nd_role == rbl_pkg::ROLE_ACTIVE, 4'd0, 1'b0, 4'd0);
        i = 0;
        while (i < nd_future.size()) begin
          e = nd_future[i];
          if (e.rnd == nd_round) begin
            nd_future.delete(i);
            hear_bit(e.snd, e.bit_v, e.act, e.port);
          end else begin
            i++;
          end
        end
        if (nd_nodes == 5'd1 || nd_neigh == 4'd0) judge_round();
      end
      rbl_pkg::MODE_BIT: begin
        if (r.rnd > nd_round) begin
          if (nd_future.size() < FUT_DEPTH) begin
            e.port = r.port; e.act = r.sact; e.rnd = r.rnd; e.bit_v = r.bitv; e.snd = r.snd;
            nd_future = {nd_future, e};
          end else begin
            nd_ovf = 1'b1;
          end
        end else if (r.rnd == nd_round) begin
          hear_bit(r.snd, r.bitv, r.sact, r.port);
        end
      end
      rbl_pkg::MODE_ANNOUNCE: begin
        if (nd_role == rbl_pkg::ROLE_ACTIVE) begin
          drop_out();
          note_action(rbl_pkg::ACT_FWD_ANN, 4'd0, 1'b0, 16'd0, 1'b0, r.port, 1'b1, r.ldr);
        end
      end
      default: ;
    endcase
    if (step_actions.size() > 0) step_actions[step_actions.size() - 1].last = 1'b1;
  endfunction

  // ---------------------------------------------------------------------
  // Output side: random stall, checking, watchdog
  // ---------------------------------------------------------------------
  initial out_stall_i = 1'b0;
  always @(posedge clk_i) out_stall_i <= ($urandom_range(99) < stall_pct);

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fails++;
    end
  endtask

  int quiet_cycles = 0;
  always @(posedge clk_i) begin
    action_t w;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_actions.size() == 0) begin
          $error("action %0d with no request waiting for it", action_o);
          fails++;
        end else begin
          w = pending_actions.pop_front();
          check_field("action", 16'(w.action), 16'(action_o));
          check_field("node_role", 16'(w.role), 16'(node_role_o));
          check_field("out_sender", 16'(w.snd), 16'(out_sender_o));
          check_field("out_bit", 16'(w.bitv), 16'(out_bit_o));
          check_field("out_round", w.rnd, out_round_o);
          check_field("out_active", 16'(w.act), 16'(out_active_o));
          check_field("skip_port", 16'(w.skip_port), 16'(skip_port_o));
          check_field("skip_valid", 16'(w.skip_valid), 16'(skip_valid_o));
          check_field("out_leader", 16'(w.leader), 16'(out_leader_o));
          check_field("buffer_overflow", 16'(w.ovf), 16'(buffer_overflow_o));
          check_field("last", 16'(w.last), 16'(last_o));
        end
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG) begin
        $display("random_bit_leader_election_node_unit test failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------
  // one request: optional idle gap, handshake, then predict on acceptance
  task automatic send(row_t row);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    mode_i <= row.req.mode;
    sender_id_i <= row.req.snd;
    bit_value_i <= row.req.bitv;
    round_number_i <= row.req.rnd;
    sender_active_i <= row.req.sact;
    arrival_port_i <= row.req.port;
    announced_leader_i <= row.req.ldr;
    random_bit_i <= row.req.rbit;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    predict_request(row.req);
    if (!row.typed) begin
      foreach (step_actions[k]) pending_actions = {pending_actions, step_actions[k]};
    end else if (!row.silent) begin
      pending_actions = {pending_actions, row.want};
    end
  endtask

  // wait for every expected action, then for any replay still running
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_actions.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // writes all three registers on consecutive edges; node count reloads the bitmap
  task automatic apply_setting(logic [3:0] own, logic [4:0] nodes, logic [3:0] neigh);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= rbl_pkg::CFG_OWN_ID;
    cfg_data_i <= {1'b0, own};
    @(posedge clk_i);
    cfg_idx_i <= rbl_pkg::CFG_NODE_CNT;
    cfg_data_i <= nodes;
    @(posedge clk_i);
    cfg_idx_i <= rbl_pkg::CFG_NEIGH_CNT;
    cfg_data_i <= {1'b0, neigh};
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    nd_own = own;
    nd_nodes = nodes;
    nd_active = (nodes >= 16) ? 16'hFFFF : 16'((32'd1 << nodes) - 1);
    nd_neigh = neigh;
  endtask

  function automatic row_t mk_row(logic [1:0] mode, logic [3:0] snd, logic b,
                                  logic [15:0] rnd, logic sact, logic [3:0] port,
                                  logic [3:0] ldr, logic rbit);
    row_t r;
    r.req.mode = mode; r.req.snd = snd; r.req.bitv = b; r.req.rnd = rnd;
    r.req.sact = sact; r.req.port = port; r.req.ldr = ldr; r.req.rbit = rbit;
    r.typed = 1'b0; r.silent = 1'b0;
    r.want = '{rbl_pkg::ACT_BCAST, 2'd0, 4'd0, 1'b0, 16'd0, 1'b0, 4'd0, 1'b0, 4'd0,
               1'b0, 1'b0};
    return r;
  endfunction

  // mostly well-formed rounds: ticks, current-round bits from the peers,
  // some early bits for the replay buffer, then stale rounds and noise
  function automatic row_t random_row();
    row_t r;
    int pick;
    int span;
    int ahead;
    r = mk_row(2'($urandom), 4'($urandom), 1'($urandom), 16'($urandom), 1'($urandom),
               4'($urandom), 4'($urandom), 1'($urandom));
    span = (nd_nodes == 0) ? 1 : ((nd_nodes > 16) ? 16 : nd_nodes);
    pick = $urandom_range(99);
    if (pick < 14) begin
      r.req.mode = rbl_pkg::MODE_TICK;
    end else if (pick < 68) begin
      r.req.mode = rbl_pkg::MODE_BIT;
      r.req.rnd = nd_round;
      if ($urandom_range(9) != 0) r.req.snd = 4'($urandom_range(span - 1));
    end else if (pick < 80) begin
      r.req.mode = rbl_pkg::MODE_BIT;
      ahead = int'(nd_round) + $urandom_range(3, 1);
      r.req.rnd = (ahead > 65535) ? 16'hFFFF : 16'(ahead);
      r.req.snd = 4'($urandom_range(span - 1));
    end else if (pick < 86) begin
      r.req.mode = rbl_pkg::MODE_BIT;
    end else if (pick < 93) begin
      r.req.mode = allow_announce ? rbl_pkg::MODE_ANNOUNCE : rbl_pkg::MODE_BIT;
    end else begin
      r.req.mode = rbl_pkg::MODE_NONE;
    end
    return r;
  endfunction

  row_t script[$];

  // directed rows; reset settings: own id 0, 16 nodes, 15 neighbours
  task automatic build_script();
    row_t r;
    int i;
    // first tick after reset: round 1, own bit broadcast
    r = mk_row(rbl_pkg::MODE_TICK, 4'd9, 1'b0, 16'd77, 1'b0, 4'd3, 4'd2, 1'b1);
    r.typed = 1'b1;
    r.want = '{rbl_pkg::ACT_BCAST, rbl_pkg::ROLE_ACTIVE, 4'd0, 1'b1, 16'd1, 1'b1, 4'd0,
               1'b0, 4'd0, 1'b0, 1'b1};
    script = {script, r};
    // unknown mode, all fields high: nothing
    r = mk_row(rbl_pkg::MODE_NONE, 4'hF, 1'b1, 16'hFFFF, 1'b1, 4'hF, 4'hF, 1'b1);
    r.typed = 1'b1; r.silent = 1'b1;
    script = {script, r};
    // own echo and stale round: nothing
    r = mk_row(rbl_pkg::MODE_BIT, 4'd0, 1'b1, 16'd1, 1'b1, 4'd4, 4'd0, 1'b0);
    r.typed = 1'b1; r.silent = 1'b1;
    script = {script, r};
    r = mk_row(rbl_pkg::MODE_BIT, 4'd5, 1'b1, 16'd0, 1'b1, 4'd4, 4'd0, 1'b0);
    r.typed = 1'b1; r.silent = 1'b1;
    script = {script, r};
    // new sender of the current round is forwarded
    r = mk_row(rbl_pkg::MODE_BIT, 4'd15, 1'b1, 16'd1, 1'b0, 4'd15, 4'd0, 1'b0);
    r.typed = 1'b1;
    r.want = '{rbl_pkg::ACT_FWD_BIT, rbl_pkg::ROLE_ACTIVE, 4'd15, 1'b1, 16'd1, 1'b0,
               4'd15, 1'b1, 4'd0, 1'b0, 1'b1};
    script = {script, r};
    // same sender again: nothing
    r.typed = 1'b1; r.silent = 1'b1;
    script = {script, r};
    // fill the buffer, far and near rounds mixed; the ninth is dropped
    for (i = 0; i < 9; i++) begin
      r = mk_row(rbl_pkg::MODE_BIT, 4'(i + 1), i[0], (i < 4) ? 16'hFFFF : 16'd2, i[1],
                 4'(i), 4'd0, 1'b0);
      script = {script, r};
    end
    // next forward shows the sticky overflow flag
    r = mk_row(rbl_pkg::MODE_BIT, 4'd14, 1'b0, 16'd1, 1'b1, 4'd0, 4'd0, 1'b0);
    script = {script, r};
    // round 2 replays its buffered messages in arrival order
    r = mk_row(rbl_pkg::MODE_TICK, 4'd0, 1'b0, 16'd0, 1'b0, 4'd0, 4'd0, 1'b0);
    script = {script, r};
    r = mk_row(rbl_pkg::MODE_TICK, 4'd0, 1'b0, 16'd0, 1'b0, 4'd0, 4'd0, 1'b1);
    script = {script, r};
  endtask

  logic [3:0] ph_own[PHASES]   = '{4'd3, 4'd15, 4'd7, 4'd2, 4'd9, 4'd5, 4'd0, 4'd12};
  logic [4:0] ph_nodes[PHASES] = '{5'd4, 5'd16, 5'd3, 5'd0, 5'd31, 5'd2, 5'd1, 5'd5};
  logic [3:0] ph_neigh[PHASES] = '{4'd2, 4'd15, 4'd0, 4'd15, 4'd1, 4'd15, 4'd5, 4'd3};
  int ph_idle[4]  = '{0, 55, 0, 32};
  int ph_stall[4] = '{0, 0, 55, 32};

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0; cfg_idx_i = rbl_pkg::CFG_OWN_ID; cfg_data_i = '0;
    in_valid_i = 1'b0; mode_i = rbl_pkg::MODE_TICK; sender_id_i = '0; bit_value_i = 1'b0;
    round_number_i = '0; sender_active_i = 1'b0; arrival_port_i = '0;
    announced_leader_i = '0; random_bit_i = 1'b0;
    nd_own = 4'd0; nd_nodes = 5'd16; nd_neigh = 4'd15; nd_role = rbl_pkg::ROLE_ACTIVE;
    nd_round = '0; nd_mybit = 1'b0; nd_heard = '0; nd_ones = '0;
    nd_active = 16'hFFFF; nd_ovf = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    build_script();
    foreach (script[k]) send(script[k]);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      apply_setting(ph_own[p], ph_nodes[p], ph_neigh[p]);
      idle_pct = ph_idle[p % 4];
      stall_pct = ph_stall[p % 4];
      allow_announce = (p == PHASES - 1);
      repeat (PHASE_REQS) send(random_row());
      drain();
    end

    if (fails == 0)
      $display("random_bit_leader_election_node_unit test passed");
    else
      $display("random_bit_leader_election_node_unit test failed");
    $finish;
  end

endmodule
